@@ sv/continuity_detector_with_hold_defines.svh @@
// Assertion macros for the continuity detector checker.
// Used by cdh_checker.sv; expects clk and rst in the enclosing scope.
`ifndef CONTINUITY_DETECTOR_WITH_HOLD_DEFINES_SVH
`define CONTINUITY_DETECTOR_WITH_HOLD_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CDH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("continuity_detector_with_hold: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CDH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("continuity_detector_with_hold: next-cycle check failed");

`endif

@@ sv/cdh_pkg.sv @@
// Shared types and constants of the continuity detector.
// No dependencies; imported by cdh_div and continuity_detector_with_hold.
package cdh_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_EXCITE_MV     = 3'd0;
  localparam logic [2:0] REG_REF_OHM       = 3'd1;
  localparam logic [2:0] REG_CAL_GAIN      = 3'd2;
  localparam logic [2:0] REG_CAL_OFFSET    = 3'd3;
  localparam logic [2:0] REG_ON_THRESHOLD  = 3'd4;
  localparam logic [2:0] REG_OFF_THRESHOLD = 3'd5;

  // Reset values of the configuration registers
  localparam logic [12:0] EXCITE_RST = 13'd3300;
  localparam logic [15:0] REF_RST    = 16'd200;
  localparam logic [15:0] GAIN_RST   = 16'd16384;
  localparam logic [15:0] OFFSET_RST = 16'd0;
  localparam logic [23:0] ON_RST     = 24'd2560;
  localparam logic [23:0] OFF_RST    = 24'd5120;

  // Behavior constants
  localparam logic [31:0] HOLD_MS        = 32'd120;
  localparam logic [13:0] OPEN_MARGIN_MV = 14'd20;
  localparam logic [23:0] RES_MAX        = 24'hFFFFFF;

  // Divider geometry: 36-bit dividend, 13-bit divisor, 32 quotient bits
  localparam int DIVIDEND_W = 36;
  localparam int DIVISOR_W  = 13;
  localparam int QUOT_W     = 32;
  localparam int DIV_CNT_W  = 5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CAL,
    ST_ADJ,
    ST_FIN
  } state_t;

endpackage

@@ sv/continuity_detector_with_hold.sv @@
// Continuity detector with hold: divider resistance, calibration and beep hysteresis.
// Depends on cdh_pkg and instantiates cdh_div.
//
// A reading passes through ST_MUL, which forms the product and starts the divider, then
// through ST_DIV for the single-bit iterative divider, and then through ST_CAL, ST_ADJ and
// ST_FIN for calibration, clamping and hysteresis. The block is ready again in the cycle
// after the result loads. A faulted or open-circuit reading skips the divider and goes from
// ST_MUL straight to ST_FIN, where its result loads. The block takes one reading at a time;
// s_tready is high only while idle. A finished result sits in the output register until
// taken, and the block already accepts the next reading meanwhile; that reading holds its
// result until the register is free. Configuration writes land at once and must be made
// while idle.
module continuity_detector_with_hold import cdh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [11:0] adc_mv, [43:12] now_ms, [47:44] zero
  input  logic        s_tuser,   // [0] adc_fault
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [23:0] resistance, [24] beep, [31:25] zero
  output logic        m_tuser    // [0] open_flag
);

  // Configuration registers
  logic [12:0]        excite_mv;
  logic [15:0]        ref_ohm;
  logic signed [15:0] cal_gain;
  logic signed [15:0] cal_offset;
  logic [23:0]        on_threshold;
  logic [23:0]        off_threshold;

  // Sequencer
  state_t state, state_next;
  logic   in_xfer;
  logic   div_start;
  logic   div_done;
  logic   out_load;

  // Item registers
  logic [11:0]        adc_mv;
  logic [31:0]        now_ms;
  logic               fault;
  logic               is_open;
  logic signed [48:0] prod;
  logic signed [35:0] cal;

  // Hysteresis state
  logic        cont_on, cont_on_next;
  logic [31:0] hold_start, hold_start_next;

  // Output register
  logic [23:0] out_res;
  logic        out_beep;
  logic        out_open;

  // Front-end combinational values
  logic signed [13:0]     margin;
  logic                   open_now;
  logic [DIVIDEND_W-1:0]  num;
  logic [QUOT_W-1:0]      quot;

  // Calibration and final values
  logic signed [48:0] prod_bias;
  logic signed [48:0] prod_rnd;
  logic signed [35:0] cal_sum;
  logic [23:0]        res;
  logic               cond;
  logic               beep_val;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      excite_mv     <= EXCITE_RST;
      ref_ohm       <= REF_RST;
      cal_gain      <= signed'(GAIN_RST);
      cal_offset    <= signed'(OFFSET_RST);
      on_threshold  <= ON_RST;
      off_threshold <= OFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXCITE_MV:     excite_mv     <= cfg_data[12:0];
        REG_REF_OHM:       ref_ohm       <= cfg_data[15:0];
        REG_CAL_GAIN:      cal_gain      <= signed'(cfg_data[15:0]);
        REG_CAL_OFFSET:    cal_offset    <= signed'(cfg_data[15:0]);
        REG_ON_THRESHOLD:  on_threshold  <= cfg_data;
        REG_OFF_THRESHOLD: off_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_xfer = s_tvalid && s_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid)                   state_next = ST_MUL;
      ST_MUL:  state_next = (fault || open_now) ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_done)                   state_next = ST_CAL;
      ST_CAL:  state_next = ST_ADJ;
      ST_ADJ:  state_next = ST_FIN;
      ST_FIN:  if (!m_tvalid || m_tready)      state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_MUL:  div_start = !fault && !open_now;
      ST_FIN:  out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      adc_mv <= s_tdata[11:0];
      now_ms <= s_tdata[43:12];
      fault  <= s_tuser;
    end
  end

  // Margin, open test and divider numerator
  always_comb begin
    margin   = signed'({1'b0, excite_mv}) - signed'({2'b00, adc_mv});
    open_now = margin < signed'(OPEN_MARGIN_MV);
    num      = {DIVIDEND_W'(ref_ohm * adc_mv)} << 8;
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      is_open <= open_now;
    end
  end

  cdh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (margin[DIVISOR_W-1:0]),
    .done     (div_done),
    .quotient (quot)
  );

  // Gain multiply, then truncating scale and offset
  always_comb begin
    prod_bias = prod[48] ? 49'sd16383 : 49'sd0;
    prod_rnd  = prod + prod_bias;
    cal_sum   = 36'(signed'(prod_rnd[48:14])) + 36'(cal_offset);
  end

  always_ff @(posedge clk) begin
    if (state == ST_CAL) begin
      prod <= 49'(cal_gain) * signed'({1'b0, quot});
    end
    if (state == ST_ADJ) begin
      cal <= cal_sum;
    end
  end

  // Clamp and hysteresis
  always_comb begin
    priority if (is_open) begin
      res = RES_MAX;
    end else if (cal[35]) begin
      res = '0;
    end else if (cal[34:24] != '0) begin
      res = RES_MAX;
    end else begin
      res = cal[23:0];
    end

    if (!cont_on) begin
      cond = !is_open && (res < on_threshold);
    end else begin
      cond = is_open || (res > off_threshold);
    end

    cont_on_next    = cont_on;
    hold_start_next = hold_start;
    if (!fault) begin
      if (cond) begin
        if (hold_start == '0) begin
          hold_start_next = now_ms;
        end else if ((now_ms - hold_start) > HOLD_MS) begin
          cont_on_next    = !cont_on;
          hold_start_next = '0;
        end
      end else begin
        hold_start_next = '0;
      end
    end
    beep_val = !fault && cont_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cont_on    <= 1'b0;
      hold_start <= '0;
    end else if (out_load) begin
      cont_on    <= cont_on_next;
      hold_start <= hold_start_next;
    end
  end

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res  <= fault ? '0 : res;
      out_open <= !fault && is_open;
      out_beep <= beep_val;
    end
  end

  assign m_tdata = {7'd0, out_beep, out_res};
  assign m_tuser = out_open;

endmodule

@@ sv/cdh_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cdh_pkg for the operand widths.
module cdh_div import cdh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIVIDEND_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]   divisor,
  output logic                   done,
  output logic [QUOT_W-1:0]      quotient
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W-1:0]  rem;
  logic [QUOT_W-1:0]     q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, q[QUOT_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  assign done     = busy && (cnt == '0);
  assign quotient = q;

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(QUOT_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath: the top dividend bits sit below any divisor of 20 or more,
  // so they load straight into the remainder and need no step of their own
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
      q   <= dividend[QUOT_W-1:0];
    end else if (busy) begin
      if (!diff[DIVISOR_W]) begin
        rem <= diff[DIVISOR_W-1:0];
        q   <= {q[QUOT_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIVISOR_W-1:0];
        q   <= {q[QUOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ sv/cdh_checker.sv @@
// Port-level checks of the continuity detector, bound to the top level.
// Depends on continuity_detector_with_hold_defines.svh for the assertion macros.
`include "continuity_detector_with_hold_defines.svh"

module cdh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result holds
  `CDH_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // A reading keeps the block busy after its transfer
  `CDH_ASSERT_NXT(a_busy_after_xfer, s_tvalid && s_tready, !s_tready)

  // An open reading shows full-scale resistance
  `CDH_ASSERT_IMP(a_open_full_scale, m_tvalid && m_tuser, m_tdata[23:0] == 24'hFFFFFF)

  // An idle block with nothing pending invents no result
  `CDH_ASSERT_NXT(a_no_spurious, s_tready && !s_tvalid && !m_tvalid, !m_tvalid)

endmodule

bind continuity_detector_with_hold cdh_checker u_cdh_checker (.*);
